// File: sv/mbps_pkg.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scanner package
// Shared constants, register indexes and the result record.
// ----------------------------------------------------------------------------
package mbps_pkg;

   // Depth of the byte history kept by the scanner.
   localparam int PATTERN_MAX  = 16;
   // The mask and pattern registers hold sixteen bytes, so longer windows are unused.
   localparam int MASK_BITS    = 16;
   localparam int WINDOW_DEPTH = (PATTERN_MAX < MASK_BITS) ? PATTERN_MAX : MASK_BITS;

   localparam int BYTE_W     = 8;
   localparam int LENGTH_W   = 5;
   localparam int COUNT_W    = 8;
   localparam int OFFSET_W   = 32;
   localparam int PAT_IDX_W  = $clog2(MASK_BITS);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [LENGTH_W-1:0] LENGTH_CAP = LENGTH_W'(WINDOW_DEPTH);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPARE_MASK = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OCC_TARGET   = 3'd4;

   // What one window cell compares against.
   typedef struct packed {
      logic              care;
      logic [BYTE_W-1:0] pattern;
   } cell_cfg_type;

   // One result item.
   typedef struct packed {
      logic                match_found;
      logic [OFFSET_W-1:0] match_offset;
      logic [COUNT_W-1:0]  occurrence_index;
      logic                scan_finished;
      logic                all_found;
   } rsp_item_type;

endpackage

// File: sv/mbps_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one byte of the image history and compares the byte it is about to
// take against its assigned pattern byte.
// ----------------------------------------------------------------------------
module mbps_cell (
   input  logic                  clock,
   input  logic                  shift_en,
   input  logic [7:0]            byte_in,
   input  mbps_pkg::cell_cfg_type cfg,
   output logic [7:0]            byte_out,
   output logic                  hit
);
   import mbps_pkg::*;

   logic [BYTE_W-1:0] hold_ff;
   logic [BYTE_W-1:0] hold_in;

   assign hold_in = shift_en ? byte_in : hold_ff;

   // The history needs no reset: only bytes of the current image are ever compared.
   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   assign byte_out = hold_ff;
   assign hit      = !cfg.care || (byte_in == cfg.pattern);

endmodule

// File: sv/mbps_window.sv
// ----------------------------------------------------------------------------
// Byte window
// A row of cells shifting the image history by one byte per transfer. Each
// cell is told which pattern byte lines up with it for the current length.
// ----------------------------------------------------------------------------
module mbps_window (
   input  logic                            clock,
   input  logic                            shift_en,
   input  logic [7:0]                      new_byte,
   input  logic [mbps_pkg::LENGTH_W-1:0]   length,
   input  logic [127:0]                    pattern,
   input  logic [mbps_pkg::MASK_BITS-1:0]  mask,
   output logic                            window_hit
);
   import mbps_pkg::*;

   logic [MASK_BITS-1:0][BYTE_W-1:0] pattern_bytes;
   logic [WINDOW_DEPTH-1:0][BYTE_W-1:0] cell_bytes;
   logic [WINDOW_DEPTH-1:0][BYTE_W-1:0] cell_feed;
   logic [WINDOW_DEPTH-1:0]             cell_hits;
   cell_cfg_type [WINDOW_DEPTH-1:0]     cell_cfgs;

   assign pattern_bytes = pattern;

   for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
      localparam logic [LENGTH_W-1:0] CELL_POS = LENGTH_W'(k);
      logic [LENGTH_W-1:0] pat_pos;

      // Cell k holds the byte k places back, which meets pattern byte length-1-k.
      assign pat_pos = length - CELL_POS - LENGTH_W'(1);

      always_comb begin
         cell_cfgs[k].pattern = pattern_bytes[pat_pos[PAT_IDX_W-1:0]];
         cell_cfgs[k].care    = (CELL_POS < length) &&
                                ((pat_pos == '0) || mask[pat_pos[PAT_IDX_W-1:0]]);
      end

      if (k == 0) begin : g_head
         assign cell_feed[k] = new_byte;
      end else begin : g_body
         assign cell_feed[k] = cell_bytes[k-1];
      end

      mbps_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .byte_in  (cell_feed[k]),
         .cfg      (cell_cfgs[k]),
         .byte_out (cell_bytes[k]),
         .hit      (cell_hits[k])
      );
   end

   assign window_hit = &cell_hits;

endmodule

// File: sv/mbps_rsp_buf.sv
// ----------------------------------------------------------------------------
// Result buffer
// Output register plus a skid slot, so the scanner keeps taking bytes while a
// result waits for the consumer.
// ----------------------------------------------------------------------------
module mbps_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  mbps_pkg::rsp_item_type push_item,
   output logic                   push_ready,
   output logic                   out_valid,
   output mbps_pkg::rsp_item_type out_item,
   input  logic                   out_ready
);
   import mbps_pkg::*;

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type main_item_ff, main_item_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         pop;

   assign pop = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_item_in  = main_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_item_in  = skid_item_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_item_in  = push_item;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_item_in  = push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_item_ff <= main_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_item   = main_item_ff;

endmodule

// File: sv/masked_byte_pattern_scanner_core.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scanner core
// Streams an image one byte per transfer and reports every masked pattern
// match up to a configured count, plus a final status on the last byte.
// ----------------------------------------------------------------------------
// The scanner takes one image byte per clock cycle, back to back, and a byte
// that ends a match or the image gives its result on rsp_ in the cycle after
// the req_ transfer when no earlier result is still waiting. The rate is set by
// the row of window cells: every byte shifts
// the history by one cell and all cells compare in parallel in that same
// cycle. A two-entry result buffer (output register and skid slot) lets the
// input keep flowing while a result waits; req_tready falls only when both
// entries are full. Each match reports its start offset and zero-based
// occurrence number; pattern byte 0 is always compared, the others only where
// their compare_mask bit is set, and overlapping matches all count. Once
// occurrence_target matches are found, later matches are dropped. The result
// for the byte marked by req_tlast carries rsp_tlast and all_found, and the
// offset and match counters then start over for the next image. Write the
// configuration registers only while no result is pending.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_core (
   input  logic                              clock,
   input  logic                              reset,
   // Image byte input.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] image_byte
   input  logic                              req_tlast,  // last_byte
   // Result output.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [39:0]                       rsp_tdata,  // [31:0] match_offset,
                                                         // [39:32] occurrence_index
   output logic [1:0]                        rsp_tuser,  // [0] match_found, [1] all_found
   output logic                              rsp_tlast,  // scan_finished
   // Configuration write channel.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mbps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]   csr_data
);
   import mbps_pkg::*;

   // Configuration registers.
   logic [63:0]          pattern_low_ff;
   logic [63:0]          pattern_high_ff;
   logic [MASK_BITS-1:0] compare_mask_ff;
   logic [LENGTH_W-1:0]  pattern_length_ff;
   logic [COUNT_W-1:0]   occ_target_ff;

   // Scan state.
   logic [OFFSET_W-1:0]  bytes_seen_ff, bytes_seen_in;
   logic [COUNT_W-1:0]   found_count_ff, found_count_in;

   logic                 accept;
   logic                 csr_write;
   logic [LENGTH_W-1:0]  eff_length;
   logic                 window_hit;
   logic                 fits;
   logic                 match;
   logic [COUNT_W-1:0]   found_after;
   logic                 push;
   logic                 buf_ready;
   rsp_item_type         push_item;
   rsp_item_type         out_item;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_tready = buf_ready;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         compare_mask_ff   <= '1;
         pattern_length_ff <= LENGTH_W'(1);
         occ_target_ff     <= COUNT_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pattern_low_ff    <= csr_data;
            CSR_PATTERN_HIGH: pattern_high_ff   <= csr_data;
            CSR_COMPARE_MASK: compare_mask_ff   <= csr_data[MASK_BITS-1:0];
            CSR_PATTERN_LEN:  pattern_length_ff <= csr_data[LENGTH_W-1:0];
            CSR_OCC_TARGET:   occ_target_ff     <= csr_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // A zero length behaves as one, and a length past the window is clipped.
   always_comb begin
      if (pattern_length_ff == '0) begin
         eff_length = LENGTH_W'(1);
      end else if (pattern_length_ff > LENGTH_CAP) begin
         eff_length = LENGTH_CAP;
      end else begin
         eff_length = pattern_length_ff;
      end
   end

   mbps_window u_window (
      .clock      (clock),
      .shift_en   (accept),
      .new_byte   (req_tdata),
      .length     (eff_length),
      .pattern    ({pattern_high_ff, pattern_low_ff}),
      .mask       (compare_mask_ff),
      .window_hit (window_hit)
   );

   // The pattern only counts once the image holds enough bytes to contain it.
   // The compare is one bit wider so the count still works across a wrap.
   assign fits  = ({1'b0, bytes_seen_ff} + (OFFSET_W+1)'(1)) >= (OFFSET_W+1)'(eff_length);
   assign match = fits && (found_count_ff < occ_target_ff) && window_hit;
   assign found_after = found_count_ff + COUNT_W'(match);

   always_comb begin
      push_item.match_found      = match;
      push_item.match_offset     = match ?
         (bytes_seen_ff + OFFSET_W'(1) - OFFSET_W'(eff_length)) : '0;
      push_item.occurrence_index = match ? found_count_ff : '0;
      push_item.scan_finished    = req_tlast;
      push_item.all_found        = req_tlast && (found_after >= occ_target_ff);
   end

   assign push = accept && (match || req_tlast);

   always_comb begin
      bytes_seen_in  = bytes_seen_ff;
      found_count_in = found_count_ff;
      if (accept) begin
         if (req_tlast) begin
            bytes_seen_in  = '0;
            found_count_in = '0;
         end else begin
            bytes_seen_in  = bytes_seen_ff + OFFSET_W'(1);
            found_count_in = found_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff  <= '0;
         found_count_ff <= '0;
      end else begin
         bytes_seen_ff  <= bytes_seen_in;
         found_count_ff <= found_count_in;
      end
   end

   mbps_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (buf_ready),
      .out_valid  (rsp_tvalid),
      .out_item   (out_item),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = {out_item.occurrence_index, out_item.match_offset};
   assign rsp_tuser = {out_item.all_found, out_item.match_found};
   assign rsp_tlast = out_item.scan_finished;

   // The last byte of an image always leaves the scan counters cleared.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> (bytes_seen_ff == '0) && (found_count_ff == '0))
      else $error("scan state not cleared after last byte");

   // Any other byte advances the offset counter by exactly one.
   a_offset_advance: assert property (@(posedge clock) disable iff (reset)
      accept && !req_tlast |=> bytes_seen_ff == $past(bytes_seen_ff) + OFFSET_W'(1))
      else $error("offset counter did not advance by one");

   // A result transfer without a match can only be the final status.
   a_nomatch_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("result without match or final status");

   // The success flag only ever appears on the final status.
   a_all_found_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("all_found set on a non-final result");

endmodule

// File: tb/masked_byte_pattern_scanner_core_tb.sv
// ----------------------------------------------------------------------------
// Masked byte pattern scanner core testbench
// Streams images through the scanner and checks every result against an
// internal scan predictor. It covers reset values, register corner cases, the
// occurrence ceiling, back-pressure and randomized images under varied idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module masked_byte_pattern_scanner_core_tb;
   import mbps_pkg::*;

   // The window depth as the scanner uses it: sixteen pattern bytes at most.
   localparam int SCAN_DEPTH  = 16;
   // Several times the slowest legal run, including all idling and stalls.
   localparam int CYCLE_LIMIT = 400000;
   // Extra cycles after the last result, enough for the result pipeline to drain.
   localparam int SETTLE_CYCLES = 4;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] image_byte
   logic        req_tlast;   // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [31:0] match_offset, [39:32] occurrence_index
   logic [1:0]  rsp_tuser;   // [0] match_found, [1] all_found
   logic        rsp_tlast;   // scan_finished
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   masked_byte_pattern_scanner_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Register copies held by the predictor. The pattern is kept as one
   // 128-bit vector so that pattern byte i sits in bits [8*i +: 8].
   logic [127:0] cfg_pattern;
   logic [15:0]  cfg_mask;
   logic [4:0]   cfg_length;
   logic [7:0]   cfg_target;

   // Scan state of the predictor; scan_window[0] is the newest byte.
   logic [7:0]  scan_window [SCAN_DEPTH];
   logic [31:0] image_pos;
   logic [7:0]  hits_found;

   // Results predicted but not yet seen on the result channel, oldest first.
   rsp_item_type expected_results [$];

   int err_count;
   int cycle_count;
   // Idle percentages for the sender and the receiver, changed per phase.
   int send_idle_pct;
   int recv_idle_pct;
   // Cycles the receiver still holds rsp_tready low; the receiver counts it down.
   int rx_hold_left;

   // -------------------------------------------------------------------------
   // Clock, cycle limit and receiver
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("masked_byte_pattern_scanner_core: mismatch");
         $finish;
      end
   end

   // The receiver either serves a requested hold-off, one cycle at a time, or
   // stalls at random with the current idle percentage.
   always @(negedge clock) begin
      if (rx_hold_left > 0) begin
         rsp_tready   <= 1'b0;
         rx_hold_left <= rx_hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Scan predictor
   // -------------------------------------------------------------------------
   // A length of zero counts as one and anything past the window is clipped.
   function automatic int active_length();
      int len;
      len = cfg_length;
      if (len == 0) len = 1;
      if (len > SCAN_DEPTH) len = SCAN_DEPTH;
      return len;
   endfunction

   // True when the pattern ends at the newest byte. Byte 0 is always
   // compared; the others only where their mask bit is set.
   function automatic bit window_holds_pattern(input int len);
      for (int i = 0; i < len; i++) begin
         if ((i == 0 || cfg_mask[i]) && scan_window[len-1-i] !== cfg_pattern[8*i +: 8])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void clear_scan_state();
      for (int i = 0; i < SCAN_DEPTH; i++) scan_window[i] = 8'h00;
      image_pos  = '0;
      hits_found = '0;
   endfunction

   // Advances the predictor by one image byte. Returns 1 and fills res when
   // the byte produces a result: a reported match, the image end, or both.
   function automatic bit predict_scan_result(input logic [7:0] image_byte,
                                              input logic last_byte,
                                              output rsp_item_type res);
      int          len;
      logic [31:0] pos;
      bit          hit;
      len = active_length();
      for (int i = SCAN_DEPTH - 1; i > 0; i--) scan_window[i] = scan_window[i-1];
      scan_window[0] = image_byte;
      pos       = image_pos;
      image_pos = pos + 32'd1;
      hit = ({1'b0, pos} + 33'd1 >= 33'(len)) && (hits_found < cfg_target) &&
            window_holds_pattern(len);
      res = '0;
      if (hit) begin
         res.match_found      = 1'b1;
         res.match_offset     = pos + 32'd1 - 32'(len);
         res.occurrence_index = hits_found;
         hits_found++;
      end
      if (!hit && !last_byte) return 1'b0;
      res.scan_finished = last_byte;
      res.all_found     = last_byte && (hits_found >= cfg_target);
      if (last_byte) clear_scan_state();
      return 1'b1;
   endfunction

   // -------------------------------------------------------------------------
   // Result checking
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      // Only the first hundred are printed so a broken block cannot flood the log.
      if (err_count < 100) $display("ERROR at %0t: %s", $time, msg);
      err_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want)
         report_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
   endtask

   // Every result transfer is matched against the oldest prediction.
   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, tdata 0x%0h",
                                      rsp_tdata));
         end else begin
            want = expected_results.pop_front();
            check_field("match_found", 32'(want.match_found), 32'(rsp_tuser[0]));
            check_field("match_offset", want.match_offset, rsp_tdata[31:0]);
            check_field("occurrence_index", 32'(want.occurrence_index),
                        32'(rsp_tdata[39:32]));
            check_field("scan_finished", 32'(want.scan_finished), 32'(rsp_tlast));
            check_field("all_found", 32'(want.all_found), 32'(rsp_tuser[1]));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   // Offers one image byte and returns at the falling edge after its transfer,
   // with tvalid still high so that back-to-back bytes need no extra cycle.
   task automatic send_image_byte(input logic [7:0] image_byte, input logic last_byte);
      rsp_item_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= image_byte;
      req_tlast  <= last_byte;
      do @(posedge clock); while (req_tready !== 1'b1);
      if (predict_scan_result(image_byte, last_byte, res)) expected_results.push_back(res);
      @(negedge clock);
   endtask

   // Stops offering bytes and waits until every predicted result has arrived,
   // then lets the pipeline settle so that a silent byte has left it too.
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes one register. Valid is dropped for a cycle after the transfer so
   // that consecutive writes never assign it twice in one time step.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_PATTERN_LOW:  cfg_pattern[63:0]   = value;
         CSR_PATTERN_HIGH: cfg_pattern[127:64] = value;
         CSR_COMPARE_MASK: cfg_mask            = value[15:0];
         CSR_PATTERN_LEN:  cfg_length          = value[4:0];
         CSR_OCC_TARGET:   cfg_target          = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_repeated(input logic [7:0] image_byte, input int count,
                                input logic end_image);
      for (int i = 0; i < count; i++)
         send_image_byte(image_byte, end_image && (i == count - 1));
   endtask

   // Bytes drawn from the values that most often build or break a match.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(4))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h78;
         3: return cfg_pattern[8*$urandom_range(SCAN_DEPTH-1) +: 8];
         default: return 8'($urandom);
      endcase
   endfunction

   // Random register settings. Short patterns and small targets dominate so
   // that most images reach their target; the extremes come up now and then.
   task automatic randomize_config();
      int          r;
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      if ($urandom_range(99) < 60) begin
         r = $urandom_range(9);
         write_csr(CSR_PATTERN_LOW, (r == 0) ? 64'h0 : (r == 1) ? '1 :
                   {pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                    pick_byte(), pick_byte(), pick_byte(), pick_byte()});
      end
      if ($urandom_range(99) < 60) begin
         r = $urandom_range(9);
         write_csr(CSR_PATTERN_HIGH, (r == 0) ? 64'h0 : (r == 1) ? '1 : {$urandom, $urandom});
      end
      if ($urandom_range(99) < 60) begin
         r = $urandom_range(9);
         write_csr(CSR_COMPARE_MASK, {junk[63:16],
                   (r == 0) ? 16'h0000 : (r < 4) ? 16'hFFFF : 16'($urandom)});
      end
      if ($urandom_range(99) < 60) begin
         r = $urandom_range(99);
         write_csr(CSR_PATTERN_LEN, {junk[63:5],
                   (r < 70) ? 5'($urandom_range(1, 4)) :
                   (r < 85) ? 5'($urandom_range(5, 15)) :
                   (r < 93) ? 5'd16 : (r < 96) ? 5'd0 : 5'($urandom_range(17, 31))});
      end
      if ($urandom_range(99) < 60) begin
         r = $urandom_range(99);
         write_csr(CSR_OCC_TARGET, {junk[63:8],
                   (r < 80) ? 8'($urandom_range(1, 6)) :
                   (r < 88) ? 8'($urandom_range(7, 254)) :
                   (r < 95) ? 8'd255 : 8'd0});
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   // Reset values: an all-zero one-byte pattern and a target of one. Also a
   // one-byte image, where the first byte is already the last.
   task automatic test_reset_defaults();
      send_image_byte(8'h00, 1'b0);
      send_image_byte(8'h5A, 1'b0);
      send_image_byte(8'h00, 1'b1);
      send_image_byte(8'hFF, 1'b1);
   endtask

   task automatic test_special_cases();
      // Oversized length clips to sixteen; the full-width pattern matches on
      // the last byte, so one result carries the match and the final status.
      wait_for_idle();
      write_csr(CSR_PATTERN_LOW,  64'h7766554433221100);
      write_csr(CSR_PATTERN_HIGH, 64'hFFEEDDCCBBAA9988);
      write_csr(CSR_COMPARE_MASK, 64'hFFFF);
      write_csr(CSR_PATTERN_LEN,  64'd31);
      write_csr(CSR_OCC_TARGET,   64'd255);
      for (int i = 0; i < SCAN_DEPTH; i++) send_image_byte(8'(i * 17), i == SCAN_DEPTH - 1);

      // Empty mask with junk in the upper bits: only byte 0 is compared, and
      // overlapping matches both count until the target of two is reached.
      wait_for_idle();
      write_csr(CSR_PATTERN_LOW,  64'h00000000000000FF);
      write_csr(CSR_COMPARE_MASK, 64'h123456789ABC0000);
      write_csr(CSR_PATTERN_LEN,  64'd4);
      write_csr(CSR_OCC_TARGET,   64'd2);
      send_repeated(8'hFF, 5, 1'b1);

      // Length zero acts as one; a target of zero never reports a match and
      // still ends with all_found set.
      wait_for_idle();
      write_csr(CSR_PATTERN_LEN, 64'hFFFFFFE0);
      write_csr(CSR_OCC_TARGET,  64'hDEADBEEF00000000);
      send_image_byte(8'h00, 1'b0);
      send_image_byte(8'hFF, 1'b1);

      // A length change in the middle of an image applies from the next byte.
      wait_for_idle();
      write_csr(CSR_PATTERN_LOW,  64'h7878);
      write_csr(CSR_COMPARE_MASK, 64'hFFFF);
      write_csr(CSR_PATTERN_LEN,  64'd2);
      write_csr(CSR_OCC_TARGET,   64'd3);
      send_repeated(8'h78, 3, 1'b0);
      wait_for_idle();
      write_csr(CSR_PATTERN_LEN, 64'd1);
      send_image_byte(8'h78, 1'b1);
   endtask

   // The largest target: occurrence numbers climb to 254 and the match on
   // the last byte after that is dropped.
   task automatic test_occurrence_ceiling();
      wait_for_idle();
      write_csr(CSR_PATTERN_LOW, 64'hA5);
      write_csr(CSR_PATTERN_LEN, 64'd1);
      write_csr(CSR_OCC_TARGET,  64'd255);
      send_repeated(8'hA5, 256, 1'b1);
   endtask

   // Every byte matches while the receiver holds off for a long stretch, so
   // both result slots fill and the input stalls. Then the sender pauses in
   // mid-image until everything has drained before it finishes the image.
   task automatic test_backpressure();
      int saved_send_pct;
      saved_send_pct = send_idle_pct;
      wait_for_idle();
      write_csr(CSR_PATTERN_LOW, 64'h3C);
      write_csr(CSR_PATTERN_LEN, 64'd1);
      write_csr(CSR_OCC_TARGET,  64'd255);
      send_idle_pct = 0;
      @(posedge clock);
      rx_hold_left = 80;
      @(negedge clock);
      send_repeated(8'h3C, 40, 1'b0);
      wait_for_idle();
      send_repeated(8'h3C, 10, 1'b1);
      send_idle_pct = saved_send_pct;
   endtask

   // Random images, mostly built from whole pattern copies with random bytes
   // in the unmasked positions, mixed with cut-off copies and plain noise.
   task automatic test_random_images(input int item_budget);
      int         sent;
      int         img_len;
      int         len;
      int         r;
      int         cut;
      logic [7:0] img [$];
      sent = 0;
      while (sent < item_budget) begin
         wait_for_idle();
         randomize_config();
         img.delete();
         len     = active_length();
         img_len = ($urandom_range(9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 20);
         while (img.size() < img_len) begin
            r = $urandom_range(99);
            if (r < 55) begin
               for (int i = 0; i < len; i++)
                  img.push_back((i == 0 || cfg_mask[i]) ? cfg_pattern[8*i +: 8] : 8'($urandom));
            end else if (r < 70) begin
               cut = $urandom_range(len - 1);
               for (int i = 0; i < cut; i++) img.push_back(cfg_pattern[8*i +: 8]);
               img.push_back(8'($urandom));
            end else begin
               img.push_back(pick_byte());
            end
         end
         foreach (img[i]) send_image_byte(img[i], i == img.size() - 1);
         sent += img.size();
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin : main_sequence
      int drain;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      rsp_tready   = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      err_count    = 0;
      cycle_count  = 0;
      rx_hold_left = 0;
      // Register and scan state after reset.
      cfg_pattern  = '0;
      cfg_mask     = 16'hFFFF;
      cfg_length   = 5'd1;
      cfg_target   = 8'd1;
      clear_scan_state();
      // The sender idles little and the receiver much in the first phase.
      send_idle_pct = 6;
      recv_idle_pct = 48;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_special_cases();
      test_occurrence_ceiling();
      test_backpressure();
      test_random_images(22);

      // Swap the idling roles, then run with no idling at all.
      send_idle_pct = 48;
      recv_idle_pct = 6;
      test_random_images(22);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_images(20);

      // Let the last results drain, bounded, then settle.
      req_tvalid <= 1'b0;
      for (drain = 0; drain < 20000 && expected_results.size() != 0; drain++)
         @(negedge clock);
      repeat (8) @(negedge clock);
      if (expected_results.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   expected_results.size()));

      if (err_count == 0) begin
         $display("masked_byte_pattern_scanner_core: match");
      end else begin
         $display("masked_byte_pattern_scanner_core: mismatch");
      end
      $finish;
   end

endmodule
